// ===== hdl/bdph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdph_pkg
// Shared types and constants for the button debouncer with press/hold events.
// ----------------------------------------------------------------------------
package bdph_pkg;

  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 8'd1;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_HELD     = 2'd3
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] hold_ms;
  } cfg_t;

endpackage

// ===== hdl/bdph_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdph_cfg
// Configuration register file: debounce and hold times.
// ----------------------------------------------------------------------------
module bdph_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bdph_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [bdph_pkg::CFG_W-1:0]     wr_data,
  output bdph_pkg::cfg_t                 cfg
);
  import bdph_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms <= DEBOUNCE_RST;
      cfg_r.hold_ms     <= HOLD_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEBOUNCE: cfg_r.debounce_ms <= wr_data;
        REG_HOLD:     cfg_r.hold_ms     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/bdph_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdph_core
// Debounce and press/hold state; computes one event per item.
// ----------------------------------------------------------------------------
module bdph_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic                         level,
  input  logic [bdph_pkg::STAMP_W-1:0] now_ms,
  input  bdph_pkg::cfg_t               cfg,
  output bdph_pkg::event_t             ev
);
  import bdph_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2,
    PH_HELD     = 2'd3
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic                 prev_raw_r;
  logic                 accepted_r, accepted_nxt;
  logic [STAMP_W-1:0]   change_stamp_r, change_stamp_nxt;
  logic [STAMP_W-1:0]   press_stamp_r, press_stamp_nxt;
  logic [STAMP_W-1:0]   since_change, since_press;
  logic                 steady, hold_done;
  event_t               ev_c;

  assign since_change = now_ms - change_stamp_r;
  assign since_press  = now_ms - press_stamp_r;
  assign steady       = since_change >= {{(STAMP_W-CFG_W){1'b0}}, cfg.debounce_ms};
  assign hold_done    = since_press  >= {{(STAMP_W-CFG_W){1'b0}}, cfg.hold_ms};

  always_comb begin
    phase_nxt        = phase_r;
    accepted_nxt     = accepted_r;
    change_stamp_nxt = change_stamp_r;
    press_stamp_nxt  = press_stamp_r;
    ev_c             = EV_NONE;
    if (level != prev_raw_r) begin
      change_stamp_nxt = now_ms;
    end else if (steady) begin
      if (level != accepted_r) begin
        accepted_nxt = level;
        if (level) begin
          phase_nxt = PH_RELEASED;
          ev_c      = EV_RELEASED;
        end else begin
          phase_nxt       = PH_PRESSED;
          ev_c            = EV_PRESSED;
          press_stamp_nxt = now_ms;
        end
      end else begin
        unique case (phase_r)
          PH_PRESSED: begin
            if (hold_done) begin
              phase_nxt = PH_HELD;
              ev_c      = EV_HELD;
            end
          end
          PH_RELEASED: phase_nxt = PH_IDLE;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      prev_raw_r     <= 1'b1;
      accepted_r     <= 1'b1;
      change_stamp_r <= '0;
      press_stamp_r  <= '0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      prev_raw_r     <= level;
      accepted_r     <= accepted_nxt;
      change_stamp_r <= change_stamp_nxt;
      press_stamp_r  <= press_stamp_nxt;
    end
  end

  assign ev = ev_c;

endmodule

// ===== hdl/button_debounce_press_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_hold
// Debouncer for an active-low push button with pressed/released/held events.
// ----------------------------------------------------------------------------
// Each input item is one pin sample with its millisecond timestamp; each item
// yields exactly one output item carrying the event code (none, pressed,
// released, held). The block takes one item per clock unless backpressure
// stalls it; an accepted item waits in the input register, then the
// debounce/hold compare (two 32-bit subtract-and-compare paths) feeds the
// output register. Backpressure on the output stalls the input only when both
// registers are full. Configuration writes are taken at any time and must
// only be issued while no item is in flight.
module button_debounce_press_hold (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: [0] pin_level, [32:1] now_ms, [39:33] zero
  input  logic [bdph_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: [1:0] event_res, [7:2] zero
  output logic [bdph_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bdph_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdph_pkg::CFG_W-1:0]        cfg_data
);
  import bdph_pkg::*;

  cfg_t               cfg;
  event_t             ev;
  logic               s1_valid_r;
  logic               s1_level_r;
  logic [STAMP_W-1:0] s1_now_r;
  logic               s1_adv;
  logic               out_valid_r;
  event_t             out_ev_r;

  assign cfg_ready = 1'b1;

  bdph_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign s1_adv    = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_level_r <= in_tdata[0];
      s1_now_r   <= in_tdata[STAMP_W:1];
    end
  end

  bdph_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .level   (s1_level_r),
    .now_ms  (s1_now_r),
    .cfg     (cfg),
    .ev      (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ev_r <= ev;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_ev_r};

`ifndef SYNTH
  a_press_low: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && ev == EV_PRESSED) |-> !s1_level_r)
    else $error("pressed event on high pin level");

  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && ev == EV_RELEASED) |-> s1_level_r)
    else $error("released event on low pin level");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid && out_ev_r == $past(ev))
    else $error("output register did not capture event");
`endif

endmodule

// ===== dv/tb_button_debounce_press_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_press_hold
// Self-checking bench for the press/hold button debouncer.
// ----------------------------------------------------------------------------
// A short directed table covers reset behavior, zero and maximum debounce and
// hold times, timestamp wrap and an ignored register write. Random phases then
// play bouncing presses and releases with random timing under several
// settings, mixed with noise samples. Every item is predicted in order of
// acceptance and each result is compared with the oldest prediction. Input
// gaps, output stalls and one long output hold-off exercise backpressure.
// ----------------------------------------------------------------------------
module tb_button_debounce_press_hold;
  import bdph_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 85;
  localparam int LONG_STALL    = 200;
  localparam int N_ROWS        = 27;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic                 lvl;
    logic [STAMP_W-1:0]   t;
    logic                 typed;
    event_t               want;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // predicted block state
  logic               last_raw     = 1'b1;
  logic               steady_level = 1'b1;
  logic [STAMP_W-1:0] change_time  = '0;
  logic [STAMP_W-1:0] press_time   = '0;
  event_t             btn_phase    = EV_NONE;
  logic [CFG_W-1:0]   db_ms        = DEBOUNCE_RST;
  logic [CFG_W-1:0]   hold_r       = HOLD_RST;

  event_t expected_ev[$];
  int     mismatches   = 0;
  int     burst_left   = 0;
  bit     gaps_on      = 1'b1;
  logic   hold_off_req = 1'b0;
  row_t   dir_rows [0:N_ROWS-1];

  button_debounce_press_hold uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic event_t predict_event(input logic lvl, input logic [STAMP_W-1:0] t);
    event_t             ev;
    logic [STAMP_W-1:0] since_change;
    logic [STAMP_W-1:0] since_press;
    ev = EV_NONE;
    since_change = t - change_time;
    since_press  = t - press_time;
    if (lvl != last_raw) begin
      change_time = t;
    end else if (since_change >= {16'd0, db_ms}) begin
      if (lvl != steady_level) begin
        steady_level = lvl;
        if (lvl) begin
          btn_phase = EV_RELEASED;
          ev = EV_RELEASED;
        end else begin
          btn_phase = EV_PRESSED;
          ev = EV_PRESSED;
          press_time = t;
        end
      end else if (btn_phase == EV_PRESSED) begin
        if (since_press >= {16'd0, hold_r}) begin
          btn_phase = EV_HELD;
          ev = EV_HELD;
        end
      end else if (btn_phase == EV_RELEASED) begin
        btn_phase = EV_NONE;
      end
    end
    last_raw = lvl;
    return ev;
  endfunction

  // leaves in_tvalid high; callers lower it before any wait
  task automatic push_sample(input logic lvl, input logic [STAMP_W-1:0] t,
                             input logic typed, input event_t want);
    event_t ev;
    if (cfg_valid) cfg_valid <= 1'b0;
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_tdata  <= {7'd0, t, lvl};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    ev = predict_event(lvl, t);
    if (typed) ev = want;
    expected_ev.push_back(ev);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_ev.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high; the next sample lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEBOUNCE: db_ms = val;
      REG_HOLD:     hold_r = val;
      default: ;
    endcase
  endtask

  // output side: ready pattern in stretches, plus one long hold-off on request
  initial begin : out_side
    int mode;
    int len;
    int k;
    out_tready <= 1'b0;
    k = 0;
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        hold_off_req <= 1'b0;
      end
      mode = $urandom_range(0, 2);
      len  = $urandom_range(10, 60);
      repeat (len) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= (k % 3 != 1);
        endcase
        k++;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    logic [1:0] got;
    event_t     want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[1:0];
      if (expected_ev.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: event_res=%0d", got);
      end else begin
        want = expected_ev.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event_res mismatch: expected %s (%0d), got %0d", want.name(), want, got);
        end
      end
    end
  end

  initial begin : stimulus
    logic [STAMP_W-1:0] cursor;
    logic [CFG_W-1:0]   db_set;
    logic [CFG_W-1:0]   hold_set;
    logic               target;
    int                 step_max;
    int                 cnt;
    int                 n;

    dir_rows = '{
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 32'd0,          1'b1, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'd10,         1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'd59,         1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'd60,         1'b1, EV_PRESSED},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'd1059,       1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'd1060,       1'b1, EV_HELD},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'd5000,       1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 32'd5001,       1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 32'd5051,       1'b1, EV_RELEASED},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 32'd5052,       1'b0, EV_NONE},
      '{ROW_CFG, REG_DEBOUNCE, 16'd0, 1'b0, 32'd0,     1'b0, EV_NONE},
      '{ROW_CFG, REG_HOLD,     16'd0, 1'b0, 32'd0,     1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'd100,        1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'd100,        1'b1, EV_PRESSED},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'd100,        1'b1, EV_HELD},
      '{ROW_CFG, REG_DEBOUNCE, 16'hFFFF, 1'b0, 32'd0,  1'b0, EV_NONE},
      '{ROW_CFG, REG_HOLD,     16'hFFFF, 1'b0, 32'd0,  1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 32'hFFFF_FFF0,  1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 32'h0000_FFEF,  1'b1, EV_RELEASED},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 32'h0000_FFF0,  1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'h8000_0000,  1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'h7FFF_0000,  1'b1, EV_PRESSED},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'h7FFF_FFFE,  1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 32'h8000_FFFF,  1'b1, EV_HELD},
      '{ROW_CFG, REG_UNUSED,   16'h1234, 1'b0, 32'd0,  1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 32'hFFFF_FFFF,  1'b0, EV_NONE},
      '{ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 32'h0000_1233,  1'b1, EV_NONE}
    };

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        push_sample(dir_rows[r].lvl, dir_rows[r].t, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    target = 1'b1;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          db_set = 16'd0;
          hold_set = 16'd0;
        end
        1: begin
          db_set = 16'hFFFF;
          hold_set = 16'hFFFF;
        end
        default: begin
          db_set = 16'($urandom_range(0, 40));
          hold_set = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 300));
        end
      endcase
      write_reg(REG_DEBOUNCE, db_set);
      write_reg(REG_HOLD, hold_set);
      if (ph == 5) write_reg(REG_UNUSED, 16'($urandom()));
      gaps_on = (ph % 3 != 0);
      if (ph == 3) hold_off_req <= 1'b1;
      cursor   = (ph == 1) ? 32'hFFFF_0000 : $urandom();
      step_max = (int'(db_set) + int'(hold_set)) / 8 + 2;
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          push_sample(1'($urandom_range(0, 1)), $urandom(), 1'b0, EV_NONE);
          cnt++;
        end else begin
          target = ~target;
          n = $urandom_range(0, 4);
          repeat (n) begin
            cursor += $urandom_range(0, step_max / 4);
            push_sample(1'($urandom_range(0, 1)), cursor, 1'b0, EV_NONE);
          end
          cnt += n;
          n = $urandom_range(1, 24);
          repeat (n) begin
            cursor += $urandom_range(0, step_max);
            push_sample(target, cursor, 1'b0, EV_NONE);
          end
          cnt += n;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_ev.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bdph_pkg.sv
hdl/bdph_cfg.sv
hdl/bdph_core.sv
hdl/button_debounce_press_hold.sv
dv/tb_button_debounce_press_hold.sv
